// File: sv/dtsg_pkg.sv
// Shared constants, types and sine table functions for the dual-tone sample generator.
package dtsg_pkg;

    localparam int TABLE_BITS   = 10;
    localparam int PERIOD_BITS  = 16;
    localparam int QUARTER_BITS = TABLE_BITS - 2;
    localparam int QUARTER      = 1 << QUARTER_BITS;
    localparam int DIV_STEPS    = PERIOD_BITS + TABLE_BITS;
    localparam int CNT_BITS     = $clog2(DIV_STEPS + 1);
    localparam int MAG_BITS     = 8;
    localparam int TONE_BITS    = MAG_BITS + 1;
    localparam int SUM_BITS     = TONE_BITS + 1;
    localparam int SAMPLE_BITS  = 8;
    localparam int CFG_IDX_BITS = 8;

    localparam logic [63:0] AMPLITUDE   = 64'd150;
    localparam logic [63:0] Q62_HALF_PI = 64'h6487ED5110B4611A;

    localparam logic signed [SUM_BITS-1:0] SAMPLE_MAX = SUM_BITS'(127);
    localparam logic signed [SUM_BITS-1:0] SAMPLE_MIN = -SUM_BITS'(128);

    localparam logic [PERIOD_BITS-1:0] PERIOD_A_RESET = PERIOD_BITS'(882);
    localparam logic [PERIOD_BITS-1:0] PERIOD_B_RESET = PERIOD_BITS'(864);

    localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD_A      = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD_B      = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_PHASE_A = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_PHASE_B = CFG_IDX_BITS'(3);

    typedef logic [PERIOD_BITS-1:0]      t_period;
    typedef logic [TABLE_BITS-1:0]       t_index;
    typedef logic [MAG_BITS-1:0]         t_mag;
    typedef logic signed [TONE_BITS-1:0] t_tone;

    typedef struct packed {
        logic start;
        logic restart;
        logic commit;
    } t_div_ctrl;

    // Product of two unsigned Q2.62 values, kept in Q2.62.
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Divides a Taylor term by (n + 1) * (n + 2).
    function automatic logic [63:0] taylor_div(input logic [63:0] v, input int n);
        logic [63:0] q;
        case (n)
            1:       q = v / 6;
            3:       q = v / 20;
            5:       q = v / 42;
            7:       q = v / 72;
            9:       q = v / 110;
            11:      q = v / 156;
            13:      q = v / 210;
            15:      q = v / 272;
            17:      q = v / 342;
            19:      q = v / 420;
            21:      q = v / 506;
            23:      q = v / 600;
            25:      q = v / 702;
            27:      q = v / 812;
            29:      q = v / 930;
            31:      q = v / 1056;
            33:      q = v / 1190;
            35:      q = v / 1332;
            37:      q = v / 1482;
            default: q = v / 1640;
        endcase
        return q;
    endfunction

    // Sine of a Q2.62 angle in the first quadrant.
    function automatic logic [63:0] sine_q62(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic        minus;
        int          n;
        x2    = mul_q62(x, x);
        term  = x;
        sum   = x;
        minus = 1'b1;
        for (n = 1; n < 41 && term != 64'd0; n += 2) begin
            term  = taylor_div(mul_q62(term, x2), n);
            sum   = minus ? sum - term : sum + term;
            minus = !minus;
        end
        return sum;
    endfunction

    // Truncated magnitude of the tone at quarter-wave position j.
    function automatic t_mag quarter_mag(input int j);
        logic [63:0] s;
        logic [63:0] prod;
        if (j == 0) begin
            return '0;
        end
        if (j >= QUARTER) begin
            return MAG_BITS'(AMPLITUDE);
        end
        s    = sine_q62((Q62_HALF_PI >> QUARTER_BITS) * 64'(j));
        prod = (s >> 8) * AMPLITUDE;
        return MAG_BITS'(prod >> 54);
    endfunction

endpackage

// File: sv/dtsg_phase_div.sv
// Phase counter of one tone with a bit-serial divider that yields its table index.
module dtsg_phase_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dtsg_pkg::t_div_ctrl i_ctrl,
    input  dtsg_pkg::t_period   i_period,
    input  dtsg_pkg::t_period   i_start_phase,
    output dtsg_pkg::t_index    o_index,
    output logic                o_busy
);
    import dtsg_pkg::*;

    logic [CNT_BITS-1:0] r_cnt;
    t_period             r_phase;
    t_period             r_shift;
    t_period             r_rem;
    t_period             r_mod;
    t_index              r_quo;

    t_period          w_eff;
    t_period          w_load;
    logic [PERIOD_BITS:0] w_trial;
    logic             w_fit;
    t_period          n_rem;
    logic [PERIOD_BITS:0] w_next;

    always_comb begin
        w_eff = (i_period == '0) ? t_period'(1) : i_period;
        if (i_ctrl.restart) begin
            w_load = (i_start_phase < w_eff) ? i_start_phase : '0;
        end else begin
            w_load = r_phase;
        end
        w_trial = {r_rem, r_shift[PERIOD_BITS-1]};
        w_fit   = w_trial >= {1'b0, w_eff};
        n_rem   = w_fit ? PERIOD_BITS'(w_trial - {1'b0, w_eff}) : PERIOD_BITS'(w_trial);
        w_next  = {1'b0, r_mod} + (PERIOD_BITS+1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_phase <= '0;
        end else begin
            if (i_ctrl.start) begin
                r_cnt   <= CNT_BITS'(DIV_STEPS);
                r_shift <= w_load;
                r_rem   <= '0;
            end else if (r_cnt != '0) begin
                r_cnt   <= r_cnt - CNT_BITS'(1);
                r_shift <= {r_shift[PERIOD_BITS-2:0], 1'b0};
                r_rem   <= n_rem;
                r_quo   <= {r_quo[TABLE_BITS-2:0], w_fit};
                if (r_cnt == CNT_BITS'(TABLE_BITS + 1)) begin
                    r_mod <= n_rem;
                end
            end
            if (i_ctrl.commit) begin
                r_phase <= (w_next < {1'b0, w_eff}) ? PERIOD_BITS'(w_next) : '0;
            end
        end
    end

    assign o_index = r_quo;
    assign o_busy  = r_cnt != '0;

endmodule

// File: sv/dtsg_sine_rom.sv
// Sine table lookup built from a constant quarter wave with symmetry.
module dtsg_sine_rom (
    input  dtsg_pkg::t_index i_index,
    output dtsg_pkg::t_tone  o_value
);
    import dtsg_pkg::*;

    t_mag                  w_table [0:QUARTER];
    logic [1:0]            w_quad;
    logic [QUARTER_BITS:0] w_pos;
    t_mag                  w_mag;

    for (genvar j = 0; j <= QUARTER; j++) begin : g_table
        localparam t_mag MAG = quarter_mag(j);
        assign w_table[j] = MAG;
    end

    always_comb begin
        w_quad = i_index[TABLE_BITS-1:QUARTER_BITS];
        if (w_quad[0]) begin
            w_pos = (QUARTER_BITS+1)'(QUARTER) - {1'b0, i_index[QUARTER_BITS-1:0]};
        end else begin
            w_pos = {1'b0, i_index[QUARTER_BITS-1:0]};
        end
        w_mag   = w_table[w_pos];
        o_value = w_quad[1] ? -t_tone'({1'b0, w_mag}) : t_tone'({1'b0, w_mag});
    end

endmodule

// File: sv/dual_tone_sample_generator_top.sv
// Top level of the dual-tone sample generator: configuration, control and output register.
// One-bit-per-cycle restoring dividers turn each phase into a table index. A new request is
// taken only after the previous sample has been written to the output register.
// A new input is taken while the previous sample still waits in the output register.
// Synchronous active-low reset clears both phases and loads the default periods.
module dual_tone_sample_generator_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [0] restart
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,  // [7:0] sample
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dtsg_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [15:0]                       i_cfg_data
);
    import dtsg_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_OUT
    } t_state;

    t_state  r_state;
    t_period r_period_a;
    t_period r_period_b;
    t_period r_start_a;
    t_period r_start_b;
    t_tone   r_tone_a;
    t_tone   r_tone_b;
    logic    r_m_valid;
    logic [SAMPLE_BITS-1:0] r_m_data;

    t_div_ctrl w_ctrl;
    t_index    w_index_a;
    t_index    w_index_b;
    logic      w_busy_a;
    logic      w_busy_b;
    t_tone     w_rom_a;
    t_tone     w_rom_b;
    logic signed [SUM_BITS-1:0] w_sum;
    logic [SAMPLE_BITS-1:0]     w_sample;
    logic      w_accept;
    logic      w_write;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_write  = (r_state == S_OUT) && (!r_m_valid || m_axis_tready);

    assign w_ctrl.start   = w_accept;
    assign w_ctrl.restart = s_axis_tdata[0];
    assign w_ctrl.commit  = w_write;

    dtsg_phase_div u_div_a (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .i_period      (r_period_a),
        .i_start_phase (r_start_a),
        .o_index       (w_index_a),
        .o_busy        (w_busy_a)
    );

    dtsg_phase_div u_div_b (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .i_period      (r_period_b),
        .i_start_phase (r_start_b),
        .o_index       (w_index_b),
        .o_busy        (w_busy_b)
    );

    dtsg_sine_rom u_rom_a (
        .i_index (w_index_a),
        .o_value (w_rom_a)
    );

    dtsg_sine_rom u_rom_b (
        .i_index (w_index_b),
        .o_value (w_rom_b)
    );

    always_comb begin
        w_sum = SUM_BITS'(r_tone_a) + SUM_BITS'(r_tone_b);
        if (w_sum > SAMPLE_MAX) begin
            w_sample = SAMPLE_BITS'(SAMPLE_MAX);
        end else if (w_sum < SAMPLE_MIN) begin
            w_sample = SAMPLE_BITS'(SAMPLE_MIN);
        end else begin
            w_sample = SAMPLE_BITS'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_a <= PERIOD_A_RESET;
            r_period_b <= PERIOD_B_RESET;
            r_start_a  <= '0;
            r_start_b  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PERIOD_A:      r_period_a <= i_cfg_data;
                CFG_PERIOD_B:      r_period_b <= i_cfg_data;
                CFG_START_PHASE_A: r_start_a  <= i_cfg_data;
                CFG_START_PHASE_B: r_start_b  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            if (w_write) begin
                r_m_valid <= 1'b1;
                r_m_data  <= w_sample;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (!w_busy_a && !w_busy_b) begin
                        r_tone_a <= w_rom_a;
                        r_tone_b <= w_rom_b;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_write) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = r_state == S_IDLE;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign o_cfg_ready   = 1'b1;

endmodule

// File: bench/tb_dual_tone_sample_generator_top.sv
// Testbench for the dual-tone sample generator: stream traffic checked against a sample predictor.
`timescale 1ns / 100ps

module tb_dual_tone_sample_generator_top;
    import dtsg_pkg::*;

    localparam int LATENCY = PERIOD_BITS + TABLE_BITS + 2;
    localparam int ANGLE_W = PERIOD_BITS + TABLE_BITS;

    typedef enum {READY_ALWAYS, READY_MOSTLY, READY_SELDOM, READY_PERIODIC} t_ready_mode;

    typedef struct {
        logic [CFG_IDX_BITS-1:0] index;
        logic [15:0]             value;
    } t_reg_write;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [7:0]              s_axis_tdata  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [7:0]              m_axis_tdata;
    logic                    i_cfg_valid   = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index   = '0;
    logic [15:0]             i_cfg_data    = '0;

    t_period             period_a_reg, period_b_reg, start_a_reg, start_b_reg;
    t_period             phase_a, phase_b;
    logic [MAG_BITS-1:0] quarter_rom [0:QUARTER];
    logic signed [7:0]   pending_samples [$];
    logic signed [7:0]   oldest_sample;
    t_reg_write          cfg_batch [$];

    int          failures        = 0;
    int          burst_left      = 0;
    int          sender_gap_max  = 40;
    int          holdoff_request = 0;
    int          holdoff_left    = 0;
    int          pattern_left    = 0;
    t_ready_mode ready_mode      = READY_ALWAYS;

    dual_tone_sample_generator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] full;
        full = 128'(a) * 128'(b);
        return full[125:62];
    endfunction

    function automatic logic [63:0] first_quadrant_sine(input logic [63:0] x);
        logic [63:0] x_sq;
        logic [63:0] term;
        logic [63:0] acc;
        int          k;
        x_sq = q62_product(x, x);
        term = x;
        acc  = x;
        for (k = 1; k < 41 && term != 64'd0; k += 2) begin
            term = q62_product(term, x_sq) / 64'((k + 1) * (k + 2));
            acc  = (k % 4 == 1) ? acc - term : acc + term;
        end
        return acc;
    endfunction

    task automatic build_quarter_rom();
        logic [63:0] s;
        int          j;
        for (j = 0; j <= QUARTER; j++) begin
            if (j == 0) begin
                quarter_rom[j] = '0;
            end else if (j == QUARTER) begin
                quarter_rom[j] = MAG_BITS'(AMPLITUDE);
            end else begin
                s = first_quadrant_sine((Q62_HALF_PI >> QUARTER_BITS) * 64'(j));
                quarter_rom[j] = MAG_BITS'(((s >> 8) * AMPLITUDE) >> 54);
            end
        end
    endtask

    function automatic t_period active_period(input t_period p);
        return (p == '0) ? t_period'(1) : p;
    endfunction

    function automatic int tone_level(input t_period phase, input t_period period);
        logic [ANGLE_W-1:0]      angle;
        t_index                  k;
        logic [QUARTER_BITS-1:0] r;
        angle = {phase, {TABLE_BITS{1'b0}}} / ANGLE_W'(active_period(period));
        k     = angle[TABLE_BITS-1:0];
        r     = k[QUARTER_BITS-1:0];
        case (k[TABLE_BITS-1 -: 2])
            2'd0:    return int'(quarter_rom[r]);
            2'd1:    return int'(quarter_rom[QUARTER - int'(r)]);
            2'd2:    return -int'(quarter_rom[r]);
            default: return -int'(quarter_rom[QUARTER - int'(r)]);
        endcase
    endfunction

    function automatic t_period step_phase(input t_period phase, input t_period period);
        return t_period'((17'(phase) + 17'd1) % 17'(active_period(period)));
    endfunction

    function automatic logic signed [7:0] next_sample(input logic restart);
        int level;
        if (restart) begin
            phase_a = (start_a_reg < active_period(period_a_reg)) ? start_a_reg : '0;
            phase_b = (start_b_reg < active_period(period_b_reg)) ? start_b_reg : '0;
        end
        level = tone_level(phase_a, period_a_reg) + tone_level(phase_b, period_b_reg);
        if (level > SAMPLE_MAX) begin
            level = SAMPLE_MAX;
        end else if (level < SAMPLE_MIN) begin
            level = SAMPLE_MIN;
        end
        phase_a = step_phase(phase_a, period_a_reg);
        phase_b = step_phase(phase_b, period_b_reg);
        return 8'(level);
    endfunction

    function automatic void store_register(input logic [CFG_IDX_BITS-1:0] index,
                                           input logic [15:0] value);
        case (index)
            CFG_PERIOD_A:      period_a_reg = value;
            CFG_PERIOD_B:      period_b_reg = value;
            CFG_START_PHASE_A: start_a_reg  = value;
            CFG_START_PHASE_B: start_b_reg  = value;
            default: ;
        endcase
    endfunction

    function automatic t_period random_period();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 16'hFFFF;
            2, 3, 4: return t_period'($urandom_range(1, 64));
            5, 6, 7: return t_period'($urandom_range(65, 4000));
            default: return t_period'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic t_period random_start();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return t_period'($urandom_range(0, 127));
            default: return t_period'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_registers();
        foreach (cfg_batch[n]) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= cfg_batch[n].index;
            i_cfg_data  <= cfg_batch[n].value;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            store_register(cfg_batch[n].index, cfg_batch[n].value);
        end
        i_cfg_valid <= 1'b0;
        cfg_batch.delete();
    endtask

    task automatic configure(input t_period pa, input t_period pb, input t_period sa,
                             input t_period sb, input logic with_ignored);
        t_reg_write w;
        wait_idle();
        w.index = CFG_PERIOD_A;      w.value = pa; cfg_batch.push_back(w);
        w.index = CFG_PERIOD_B;      w.value = pb; cfg_batch.push_back(w);
        w.index = CFG_START_PHASE_A; w.value = sa; cfg_batch.push_back(w);
        w.index = CFG_START_PHASE_B; w.value = sb; cfg_batch.push_back(w);
        if (with_ignored) begin
            w.index = CFG_IDX_BITS'($urandom_range(int'(CFG_START_PHASE_B) + 1, 255));
            w.value = 16'($urandom);
            cfg_batch.push_back(w);
        end
        write_registers();
    endtask

    task automatic send_request(input logic restart);
        int gap;
        if (burst_left == 0) begin
            gap = (sender_gap_max == 0) ? 0 : $urandom_range(0, sender_gap_max);
            if ($urandom_range(0, 3) == 0) begin
                gap = 0;
            end
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, restart};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
        pending_samples.push_back(next_sample(restart));
    endtask

    task automatic test_reset_defaults();
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
    endtask

    task automatic test_silent_periods();
        configure('0, t_period'(1), t_period'(5), '0, 1'b1);
        send_request(1'b1);
        send_request(1'b0);
    endtask

    task automatic test_saturation();
        configure(t_period'(4), t_period'(4), t_period'(1), t_period'(1), 1'b0);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b0);
    endtask

    task automatic test_start_phase_limits();
        configure(t_period'(100), 16'hFFFF, t_period'(100), 16'hFFFE, 1'b0);
        send_request(1'b1);
        send_request(1'b0);
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, t_period'(16384), 1'b1);
        send_request(1'b1);
        send_request(1'b0);
    endtask

    task automatic test_period_shrink();
        configure(t_period'(1000), t_period'(1000), t_period'(900), t_period'(300), 1'b0);
        send_request(1'b1);
        send_request(1'b0);
        configure(t_period'(10), t_period'(7), t_period'(900), t_period'(300), 1'b0);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b0);
    endtask

    task automatic test_random_traffic();
        int setting;
        int n;
        for (setting = 0; setting < 10; setting++) begin
            configure(random_period(), random_period(), random_start(), random_start(), 1'b1);
            for (n = 0; n < 50; n++) begin
                if (n == 0) begin
                    send_request(1'($urandom_range(0, 1)));
                end else begin
                    send_request($urandom_range(0, 9) == 0);
                end
            end
        end
    endtask

    task automatic test_output_backpressure();
        int n;
        configure(t_period'(37), t_period'(53), t_period'(3), t_period'(11), 1'b0);
        sender_gap_max  = 0;
        holdoff_request = 400;
        for (n = 0; n < 16; n++) begin
            send_request(n == 0);
        end
        sender_gap_max = 40;
    endtask

    task automatic test_drain_pause();
        int n;
        for (n = 0; n < 12; n++) begin
            send_request($urandom_range(0, 7) == 0);
        end
        wait_idle();
        for (n = 0; n < 12; n++) begin
            send_request($urandom_range(0, 7) == 0);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (holdoff_request != 0) begin
            holdoff_left    = holdoff_request;
            holdoff_request = 0;
            m_axis_tready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                ready_mode   = t_ready_mode'($urandom_range(0, 3));
                pattern_left = $urandom_range(50, 400);
            end
            pattern_left--;
            case (ready_mode)
                READY_ALWAYS: m_axis_tready <= 1'b1;
                READY_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
                READY_SELDOM: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:      m_axis_tready <= ((pattern_left % 40) >= 30);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_samples.size() == 0) begin
                $error("unexpected transfer: sample %0d", $signed(m_axis_tdata));
                failures++;
            end else begin
                oldest_sample = pending_samples.pop_front();
                if (m_axis_tdata !== oldest_sample) begin
                    $error("sample: expected %0d, actual %0d", oldest_sample,
                           $signed(m_axis_tdata));
                    failures++;
                end
            end
        end
    end

    initial begin
        period_a_reg = PERIOD_A_RESET;
        period_b_reg = PERIOD_B_RESET;
        start_a_reg  = '0;
        start_b_reg  = '0;
        phase_a      = '0;
        phase_b      = '0;
        build_quarter_rom();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_silent_periods();
        test_saturation();
        test_start_phase_limits();
        test_period_shrink();
        test_random_traffic();
        test_output_backpressure();
        test_drain_pause();
        wait_idle();
        if (failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
sv/dtsg_pkg.sv
sv/dtsg_phase_div.sv
sv/dtsg_sine_rom.sv
sv/dual_tone_sample_generator_top.sv
bench/tb_dual_tone_sample_generator_top.sv
